### src/drm_pkg.sv
// Shared types, codes and helpers for the damage rectangle merger.
`default_nettype none

package drm_pkg;

    localparam int MAX_RECTS_DEF = 16;
    localparam int SCREEN_LIMIT  = 4096;
    localparam int TOUCH_GAP     = 2;

    localparam int COORD_W = 12;
    localparam int SIZE_W  = 13;
    localparam int IN_W    = 16;
    localparam int COUNT_W = 5;
    localparam int STAT_W  = 3;
    localparam int CFG_W   = 13;
    localparam int CFG_IDX_W = 1;

    // Output tdata layout
    localparam int OUT_DATA_W    = 56;
    localparam int OUT_COUNT_LSB = 50;

    // Configuration register indexes
    localparam logic [CFG_IDX_W-1:0] REG_SCREEN_WIDTH  = 1'd0;
    localparam logic [CFG_IDX_W-1:0] REG_SCREEN_HEIGHT = 1'd1;

    // Commands
    localparam logic CMD_ADD   = 1'b0;
    localparam logic CMD_DRAIN = 1'b1;

    // Result status codes
    localparam logic [STAT_W-1:0] ST_DISCARD  = 3'd0;
    localparam logic [STAT_W-1:0] ST_MERGE    = 3'd1;
    localparam logic [STAT_W-1:0] ST_APPEND   = 3'd2;
    localparam logic [STAT_W-1:0] ST_OVERFLOW = 3'd3;
    localparam logic [STAT_W-1:0] ST_ENTRY    = 3'd4;
    localparam logic [STAT_W-1:0] ST_EMPTY    = 3'd5;

    typedef struct packed {
        logic [SIZE_W-1:0]  h;
        logic [SIZE_W-1:0]  w;
        logic [COORD_W-1:0] y;
        logic [COORD_W-1:0] x;
    } rect_t;

    localparam int RECT_W = $bits(rect_t);

    // Usable screen dimension: zero reads as one, oversize saturates.
    function automatic logic [SIZE_W-1:0] screen_dim(input logic [CFG_W-1:0] r);
        logic [SIZE_W-1:0] d;
        if (r == '0)
            d = SIZE_W'(1);
        else if (r > CFG_W'(SCREEN_LIMIT))
            d = SIZE_W'(SCREEN_LIMIT);
        else
            d = r;
        return d;
    endfunction

endpackage

`default_nettype wire

### src/drm_ram.sv
// Generic single-write, single-read RAM with registered read data.
`default_nettype none

module drm_ram #(
    parameter int WIDTH = drm_pkg::RECT_W,
    parameter int DEPTH = drm_pkg::MAX_RECTS_DEF,
    localparam int AW   = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  wire logic             clk,
    input  wire logic             we,
    input  wire logic [AW-1:0]    waddr,
    input  wire logic [WIDTH-1:0] wdata,
    input  wire logic             re,
    input  wire logic [AW-1:0]    raddr,
    output logic      [WIDTH-1:0] rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (re)
        begin
            rdata <= mem[raddr];
        end
    end

endmodule

`default_nettype wire

### src/drm_clip.sv
// Clip a signed rectangle to the screen and flag an empty result.
`default_nettype none

module drm_clip (
    input  wire logic signed [drm_pkg::IN_W-1:0]  x,
    input  wire logic signed [drm_pkg::IN_W-1:0]  y,
    input  wire logic        [drm_pkg::IN_W-1:0]  w,
    input  wire logic        [drm_pkg::IN_W-1:0]  h,
    input  wire logic        [drm_pkg::CFG_W-1:0] screen_width,
    input  wire logic        [drm_pkg::CFG_W-1:0] screen_height,
    output drm_pkg::rect_t                        rect,
    output logic                                  ok
);

    localparam int EW = drm_pkg::IN_W + 2;

    logic        [drm_pkg::SIZE_W-1:0] sw;
    logic        [drm_pkg::SIZE_W-1:0] sh;
    logic signed [EW-1:0] left, top, right, bottom;
    logic signed [EW-1:0] sw_s, sh_s;
    logic signed [EW-1:0] left_c, top_c, right_c, bottom_c;
    logic signed [EW-1:0] wd, ht;

    always_comb
    begin
        sw     = drm_pkg::screen_dim(screen_width);
        sh     = drm_pkg::screen_dim(screen_height);
        sw_s   = $signed({{(EW-drm_pkg::SIZE_W){1'b0}}, sw});
        sh_s   = $signed({{(EW-drm_pkg::SIZE_W){1'b0}}, sh});
        left   = EW'(x);
        top    = EW'(y);
        right  = left + $signed({2'b00, w});
        bottom = top + $signed({2'b00, h});

        ok = (w != '0) && (h != '0) && (right > 0) && (bottom > 0)
             && (left < sw_s) && (top < sh_s);

        // Clamp each edge into the screen
        left_c   = (left < 0) ? '0 : left;
        top_c    = (top < 0) ? '0 : top;
        right_c  = (right > sw_s) ? sw_s : right;
        bottom_c = (bottom > sh_s) ? sh_s : bottom;
        wd       = right_c - left_c;
        ht       = bottom_c - top_c;

        rect.x = left_c[drm_pkg::COORD_W-1:0];
        rect.y = top_c[drm_pkg::COORD_W-1:0];
        rect.w = wd[drm_pkg::SIZE_W-1:0];
        rect.h = ht[drm_pkg::SIZE_W-1:0];
    end

endmodule

`default_nettype wire

### src/damage_rectangle_merger_unit.sv
// Damage rectangle merger: top level with table sequencer and output register.
//
// Keeps up to MAX_RECTS screen damage rectangles in a one-port-read,
// one-port-write RAM with a registered read. An add transfer (tuser 0) is
// clipped to the configured screen; an empty clip gives status "discarded".
// Otherwise the table is scanned in order for the first entry within two
// pixels; that entry grows to the bounding union and then, in one pass,
// absorbs each other entry it touches when the pass reaches it, each absorbed
// slot being refilled from the last entry. With no touching entry the
// rectangle is appended, or on a full table the table collapses to one
// full-screen entry. An add yields one status transfer carrying the new
// entry count, with tlast set. A drain transfer (tuser 1) streams every entry
// (status 4, tlast on the final one, entry_count 0) and empties the table;
// an empty table yields a single status 5 transfer. One item is worked on at
// a time: s_tready is high only while the sequencer is idle. Every table
// access goes through the RAM read port one entry at a time: an add reads
// entries in order until one touches, then reads the others in the absorb
// pass, with an extra read and write when an absorbed slot is refilled; a
// drain reads and sends each entry in turn and waits while m_tready is low.
// No clearing pass is needed after reset: entries beyond the count are never
// read. Screen size writes are taken at any time but belong between items;
// stored entries are kept when the screen changes.
`default_nettype none

module damage_rectangle_merger_unit #(
    parameter int MAX_RECTS = drm_pkg::MAX_RECTS_DEF
) (
    input  wire logic                               clk,
    input  wire logic                               rst_n,
    // Command stream
    input  wire logic                               s_tvalid,
    output logic                                    s_tready,
    input  wire logic [63:0]                        s_tdata,  // in_x, in_y, in_width, in_height
    input  wire logic                               s_tuser,  // command
    // Result stream
    output logic                                    m_tvalid,
    input  wire logic                               m_tready,
    output logic [drm_pkg::OUT_DATA_W-1:0]          m_tdata,  // out_x, out_y, out_width,
                                                              // out_height, entry_count, pad
    output logic [drm_pkg::STAT_W-1:0]              m_tuser,  // status
    output logic                                    m_tlast,  // last
    // Configuration writes
    input  wire logic                               cfg_we,
    input  wire logic [drm_pkg::CFG_IDX_W-1:0]      cfg_index,
    input  wire logic [drm_pkg::CFG_W-1:0]          cfg_data
);

    localparam int AW = (MAX_RECTS > 1) ? $clog2(MAX_RECTS) : 1;
    localparam int CW = $clog2(MAX_RECTS + 1);
    localparam int XW = drm_pkg::SIZE_W + 1;  // room for edge plus gap

    // Sequencer states
    localparam logic [3:0] S_IDLE   = 4'd0;
    localparam logic [3:0] S_CLIP   = 4'd1;
    localparam logic [3:0] S_FRD    = 4'd2;  // find: issue read
    localparam logic [3:0] S_FCHK   = 4'd3;  // find: test entry
    localparam logic [3:0] S_ARD    = 4'd4;  // absorb: issue read
    localparam logic [3:0] S_ACHK   = 4'd5;  // absorb: test entry
    localparam logic [3:0] S_AMOV   = 4'd6;  // absorb: refill slot from last
    localparam logic [3:0] S_RESULT = 4'd7;
    localparam logic [3:0] S_DRD    = 4'd8;
    localparam logic [3:0] S_DOUT   = 4'd9;

    // Two rectangles lie within the touch gap of each other
    function automatic logic near(input drm_pkg::rect_t a, input drm_pkg::rect_t b);
        logic [XW-1:0] ax, ay, bx, by, ar, ab, br, bb;
        ax = XW'(a.x);
        ay = XW'(a.y);
        bx = XW'(b.x);
        by = XW'(b.y);
        ar = XW'(a.x) + XW'(a.w) + XW'(drm_pkg::TOUCH_GAP);
        ab = XW'(a.y) + XW'(a.h) + XW'(drm_pkg::TOUCH_GAP);
        br = XW'(b.x) + XW'(b.w) + XW'(drm_pkg::TOUCH_GAP);
        bb = XW'(b.y) + XW'(b.h) + XW'(drm_pkg::TOUCH_GAP);
        return (ax <= br) && (bx <= ar) && (ay <= bb) && (by <= ab);
    endfunction

    function automatic drm_pkg::rect_t bound(input drm_pkg::rect_t a,
                                             input drm_pkg::rect_t b);
        drm_pkg::rect_t r;
        logic [XW-1:0] ar, br, ab, bb, mr, mb;
        ar  = XW'(a.x) + XW'(a.w);
        br  = XW'(b.x) + XW'(b.w);
        ab  = XW'(a.y) + XW'(a.h);
        bb  = XW'(b.y) + XW'(b.h);
        mr  = (ar > br) ? ar : br;
        mb  = (ab > bb) ? ab : bb;
        r.x = (a.x < b.x) ? a.x : b.x;
        r.y = (a.y < b.y) ? a.y : b.y;
        r.w = drm_pkg::SIZE_W'(mr - XW'(r.x));
        r.h = drm_pkg::SIZE_W'(mb - XW'(r.y));
        return r;
    endfunction

    logic [3:0]                     state_reg, state_next;
    logic [drm_pkg::CFG_W-1:0]      scr_w_reg, scr_h_reg;
    logic [63:0]                    in_data_reg, in_data_next;
    drm_pkg::rect_t                 nr_reg, nr_next;
    drm_pkg::rect_t                 cur_reg, cur_next;
    logic [AW-1:0]                  i_reg, i_next;
    logic [CW-1:0]                  j_reg, j_next;
    logic [CW-1:0]                  count_reg, count_next;
    logic [drm_pkg::STAT_W-1:0]     res_reg, res_next;

    logic                           out_valid_reg, out_valid_next;
    logic [drm_pkg::STAT_W-1:0]     out_status_reg, out_status_next;
    drm_pkg::rect_t                 out_rect_reg, out_rect_next;
    logic [drm_pkg::COUNT_W-1:0]    out_count_reg, out_count_next;
    logic                           out_last_reg, out_last_next;

    logic                           ram_we, ram_re;
    logic [AW-1:0]                  ram_waddr, ram_raddr;
    drm_pkg::rect_t                 ram_wdata, ram_rdata;

    drm_pkg::rect_t                 clip_rect;
    logic                           clip_ok;
    drm_pkg::rect_t                 full_rect;
    logic                           out_free;
    logic [CW-1:0]                  count_dec;

    drm_ram #(
        .WIDTH (drm_pkg::RECT_W),
        .DEPTH (MAX_RECTS)
    ) u_table (
        .clk   (clk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .re    (ram_re),
        .raddr (ram_raddr),
        .rdata (ram_rdata)
    );

    drm_clip u_clip (
        .x             ($signed(in_data_reg[15:0])),
        .y             ($signed(in_data_reg[31:16])),
        .w             (in_data_reg[47:32]),
        .h             (in_data_reg[63:48]),
        .screen_width  (scr_w_reg),
        .screen_height (scr_h_reg),
        .rect          (clip_rect),
        .ok            (clip_ok)
    );

    assign s_tready  = (state_reg == S_IDLE);
    assign out_free  = !out_valid_reg || m_tready;
    assign count_dec = count_reg - CW'(1);

    always_comb
    begin
        full_rect.x = '0;
        full_rect.y = '0;
        full_rect.w = drm_pkg::screen_dim(scr_w_reg);
        full_rect.h = drm_pkg::screen_dim(scr_h_reg);
    end

    always_comb
    begin
        state_next      = state_reg;
        in_data_next    = in_data_reg;
        nr_next         = nr_reg;
        cur_next        = cur_reg;
        i_next          = i_reg;
        j_next          = j_reg;
        count_next      = count_reg;
        res_next        = res_reg;
        out_valid_next  = out_valid_reg && !m_tready;
        out_status_next = out_status_reg;
        out_rect_next   = out_rect_reg;
        out_count_next  = out_count_reg;
        out_last_next   = out_last_reg;
        ram_we          = 1'b0;
        ram_waddr       = j_reg[AW-1:0];
        ram_wdata       = ram_rdata;
        ram_re          = 1'b0;
        ram_raddr       = j_reg[AW-1:0];

        unique case (state_reg)
            S_IDLE:
            begin
                if (s_tvalid)
                begin
                    in_data_next = s_tdata;
                    j_next       = '0;
                    if (s_tuser == drm_pkg::CMD_DRAIN)
                    begin
                        if (count_reg == '0)
                        begin
                            res_next   = drm_pkg::ST_EMPTY;
                            state_next = S_RESULT;
                        end
                        else
                        begin
                            state_next = S_DRD;
                        end
                    end
                    else
                    begin
                        state_next = S_CLIP;
                    end
                end
            end

            S_CLIP:
            begin
                nr_next = clip_rect;
                if (clip_ok)
                begin
                    state_next = S_FRD;
                end
                else
                begin
                    res_next   = drm_pkg::ST_DISCARD;
                    state_next = S_RESULT;
                end
            end

            S_FRD:
            begin
                if (j_reg >= count_reg)
                begin
                    // No entry touches: append, or collapse a full table
                    ram_we = 1'b1;
                    if (count_reg < CW'(MAX_RECTS))
                    begin
                        ram_waddr  = count_reg[AW-1:0];
                        ram_wdata  = nr_reg;
                        count_next = count_reg + CW'(1);
                        res_next   = drm_pkg::ST_APPEND;
                    end
                    else
                    begin
                        ram_waddr  = '0;
                        ram_wdata  = full_rect;
                        count_next = CW'(1);
                        res_next   = drm_pkg::ST_OVERFLOW;
                    end
                    state_next = S_RESULT;
                end
                else
                begin
                    ram_re     = 1'b1;
                    state_next = S_FCHK;
                end
            end

            S_FCHK:
            begin
                if (near(ram_rdata, nr_reg))
                begin
                    cur_next   = bound(ram_rdata, nr_reg);
                    i_next     = j_reg[AW-1:0];
                    j_next     = '0;
                    state_next = S_ARD;
                end
                else
                begin
                    j_next     = j_reg + CW'(1);
                    state_next = S_FRD;
                end
            end

            S_ARD:
            begin
                if (j_reg >= count_reg)
                begin
                    // Pass complete: write the grown entry back
                    ram_we     = 1'b1;
                    ram_waddr  = i_reg;
                    ram_wdata  = cur_reg;
                    res_next   = drm_pkg::ST_MERGE;
                    state_next = S_RESULT;
                end
                else if (j_reg[AW-1:0] == i_reg)
                begin
                    j_next = j_reg + CW'(1);
                end
                else
                begin
                    ram_re     = 1'b1;
                    state_next = S_ACHK;
                end
            end

            S_ACHK:
            begin
                if (near(cur_reg, ram_rdata))
                begin
                    cur_next   = bound(cur_reg, ram_rdata);
                    count_next = count_dec;
                    if (j_reg == count_dec)
                    begin
                        // Absorbed entry was the last one: nothing to move
                        state_next = S_ARD;
                    end
                    else
                    begin
                        ram_re     = 1'b1;
                        ram_raddr  = count_dec[AW-1:0];
                        state_next = S_AMOV;
                    end
                end
                else
                begin
                    j_next     = j_reg + CW'(1);
                    state_next = S_ARD;
                end
            end

            S_AMOV:
            begin
                // Refill the absorbed slot; follow the grown entry if it moved
                ram_we    = 1'b1;
                ram_waddr = j_reg[AW-1:0];
                ram_wdata = ram_rdata;
                if (CW'(i_reg) == count_reg)
                begin
                    i_next = j_reg[AW-1:0];
                end
                state_next = S_ARD;
            end

            S_RESULT:
            begin
                if (out_free)
                begin
                    out_valid_next  = 1'b1;
                    out_status_next = res_reg;
                    out_rect_next   = '0;
                    out_last_next   = 1'b1;
                    if (res_reg == drm_pkg::ST_EMPTY)
                        out_count_next = '0;
                    else
                        out_count_next = drm_pkg::COUNT_W'(count_reg);
                    state_next = S_IDLE;
                end
            end

            S_DRD:
            begin
                ram_re     = 1'b1;
                state_next = S_DOUT;
            end

            S_DOUT:
            begin
                if (out_free)
                begin
                    out_valid_next  = 1'b1;
                    out_status_next = drm_pkg::ST_ENTRY;
                    out_rect_next   = ram_rdata;
                    out_count_next  = '0;
                    out_last_next   = (j_reg + CW'(1) == count_reg);
                    if (j_reg + CW'(1) == count_reg)
                    begin
                        count_next = '0;
                        state_next = S_IDLE;
                    end
                    else
                    begin
                        j_next     = j_reg + CW'(1);
                        state_next = S_DRD;
                    end
                end
            end

            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    // Control state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            count_reg     <= '0;
            out_valid_reg <= 1'b0;
            scr_w_reg     <= drm_pkg::CFG_W'(1280);
            scr_h_reg     <= drm_pkg::CFG_W'(800);
        end
        else
        begin
            state_reg     <= state_next;
            count_reg     <= count_next;
            out_valid_reg <= out_valid_next;
            if (cfg_we)
            begin
                unique case (cfg_index)
                    drm_pkg::REG_SCREEN_WIDTH:  scr_w_reg <= cfg_data;
                    drm_pkg::REG_SCREEN_HEIGHT: scr_h_reg <= cfg_data;
                    default:                    ;
                endcase
            end
        end
    end

    // Payload and working registers
    always_ff @(posedge clk)
    begin
        in_data_reg    <= in_data_next;
        nr_reg         <= nr_next;
        cur_reg        <= cur_next;
        i_reg          <= i_next;
        j_reg          <= j_next;
        res_reg        <= res_next;
        out_status_reg <= out_status_next;
        out_rect_reg   <= out_rect_next;
        out_count_reg  <= out_count_next;
        out_last_reg   <= out_last_next;
    end

    assign m_tvalid = out_valid_reg;
    assign m_tuser  = out_status_reg;
    assign m_tlast  = out_last_reg;
    assign m_tdata  = {1'b0, out_count_reg, out_rect_reg};

endmodule

`default_nettype wire

### src/drm_chk.sv
// Port-level checker for the damage rectangle merger, bound to the top level.
`default_nettype none

module drm_chk (
    input wire logic                              clk,
    input wire logic                              rst_n,
    input wire logic                              m_tvalid,
    input wire logic                              m_tready,
    input wire logic [drm_pkg::OUT_DATA_W-1:0]    m_tdata,
    input wire logic [drm_pkg::STAT_W-1:0]        m_tuser,
    input wire logic                              m_tlast
);

    logic [drm_pkg::COUNT_W-1:0] cnt;
    logic [drm_pkg::RECT_W-1:0]  coords;

    assign cnt    = m_tdata[drm_pkg::OUT_COUNT_LSB +: drm_pkg::COUNT_W];
    assign coords = m_tdata[drm_pkg::RECT_W-1:0];

    // Hold a stalled result
    a_hold: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tuser)
                                  && $stable(m_tlast))
        else $error("result changed while stalled");

    // Every status result closes its item and carries no coordinates
    a_status_last: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && (m_tuser != drm_pkg::ST_ENTRY) |-> m_tlast && (coords == '0))
        else $error("status result not last or has coordinates");

    // Drain results report an empty table
    a_drain_count: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && (m_tuser == drm_pkg::ST_ENTRY || m_tuser == drm_pkg::ST_EMPTY)
        |-> cnt == '0)
        else $error("drain result with nonzero count");

    // Overflow collapses the table to a single entry
    a_add_count: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && (m_tuser == drm_pkg::ST_OVERFLOW) |-> cnt == drm_pkg::COUNT_W'(1))
        else $error("overflow did not leave a single entry");

endmodule

bind damage_rectangle_merger_unit drm_chk u_drm_chk (
    .clk      (clk),
    .rst_n    (rst_n),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tuser  (m_tuser),
    .m_tlast  (m_tlast)
);

`default_nettype wire
